[hdl/ssq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants of the smooth scroll sequencer
// Field widths, request kinds, status codes, register indexes and the
// packed request and result items used on the stream ports.
// ----------------------------------------------------------------------------
package ssq_pkg;

   // Default sizes for the top level parameters
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_ROW_BITS    = 8;
   localparam int DEF_MAX_LINES   = 63;

   // Fixed field widths
   localparam int LINE_W   = 7;
   localparam int TAG_W    = 8;
   localparam int ROW_W    = 8;
   localparam int OFS_W    = 6;
   localparam int MAG_W    = 5;
   localparam int CHARS_W  = 8;
   localparam int MODE_W   = 3;
   localparam int KIND_W   = 2;
   localparam int BUSY_W   = 2;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // Default width of one queue entry: direction, line count, tag, two rows
   localparam int DEF_ENTRY_W = 1 + 7 + TAG_W + 2 * ROW_W;

   // Offset and timing constants
   localparam logic [MAG_W-1:0]   OFFSET_FULL   = 5'd16;
   localparam logic [ROW_W-1:0]   LAST_TOP_IDLE = 8'd2;
   localparam logic [ROW_W-1:0]   LAST_BOT_IDLE = 8'd1;
   localparam logic [MODE_W-1:0]  MODE_MIN      = 3'd1;
   localparam logic [MODE_W-1:0]  MODE_MAX      = 3'd5;
   localparam logic [CHARS_W-1:0] CHARS_MIN     = 8'd2;
   localparam logic [CHARS_W-1:0] CHARS_RESET   = 8'd16;

   // Request kinds carried on req_tuser
   typedef enum logic [KIND_W-1:0] {
      REQ_TICK    = 2'd0,
      REQ_ENQUEUE = 2'd1,
      REQ_CLEAR   = 2'd2
   } req_kind_type;

   // Status reported with every result
   typedef enum logic [BUSY_W-1:0] {
      BUSY_IDLE      = 2'd0,
      BUSY_BLOCKED   = 2'd1,
      BUSY_LINE_DONE = 2'd2
   } busy_type;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMOOTH_ENABLE = 2'd0,
      CSR_SMOOTH_MODE   = 2'd1,
      CSR_SCROLL_CHARS  = 2'd2
   } csr_idx_type;

   // One request as taken from the input channel
   typedef struct packed {
      req_kind_type              kind;
      logic [ROW_W-1:0]          region_bottom;
      logic [ROW_W-1:0]          region_top;
      logic [TAG_W-1:0]          action_tag;
      logic signed [LINE_W-1:0]  line_count;
   } req_item_type;

   // One result, first field in the highest bits
   typedef struct packed {
      busy_type                  busy_status;
      logic [TAG_W-1:0]          finish_tag;
      logic                      finish_now;
      logic [ROW_W-1:0]          offset_bottom;
      logic [ROW_W-1:0]          offset_top;
      logic signed [OFS_W-1:0]   pixel_offset;
      logic                      offset_write;
      logic signed [LINE_W-1:0]  move_lines;
   } rsp_item_type;

   // Offset step match for the current tick
   typedef struct packed {
      logic              hit;
      logic [MAG_W-1:0]  mag;
   } step_hit_type;

endpackage

[hdl/ssq_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_queue: scroll request storage
// One write port at the tail, one registered read port that follows the
// next head pointer; a write to the address being read is passed through.
// ----------------------------------------------------------------------------
module ssq_queue #(
   parameter int DEPTH = ssq_pkg::DEF_QUEUE_DEPTH,
   parameter int WIDTH = ssq_pkg::DEF_ENTRY_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the tail entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read the head entry, pass a same-cycle write through
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ssq_step_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_step_match: offset step position match
// Compares the tick counter with the step positions of the current mode and
// returns the magnitude of the matching step with the highest index.
// ----------------------------------------------------------------------------
module ssq_step_match (
   input  logic [ssq_pkg::MODE_W-1:0]  mode,
   input  logic [ssq_pkg::CHARS_W-1:0] chars,
   input  logic [ssq_pkg::CHARS_W-1:0] tick,
   output ssq_pkg::step_hit_type       step
);
   import ssq_pkg::*;

   localparam int HALF_MAX = 8;
   localparam int PROD_W   = CHARS_W + 5;

   logic [PROD_W-1:0] prod [HALF_MAX];
   logic [PROD_W-1:0] frac [HALF_MAX];
   logic [PROD_W-1:0] chars_x;
   logic [PROD_W-1:0] tick_x;
   logic [MAG_W-1:0]  steps;
   logic [MAG_W-1:0]  half;
   logic [MAG_W-1:0]  half_up;
   logic [MODE_W-1:0] mag_shift;
   logic              mode_ok;

   assign chars_x   = PROD_W'(chars);
   assign tick_x    = PROD_W'(tick);
   assign mode_ok   = (mode >= MODE_MIN) && (mode <= MODE_MAX);
   assign steps     = MAG_W'(1) << (mode - 3'd1);
   assign half      = steps >> 1;
   assign half_up   = (steps + 5'd1) >> 1;
   assign mag_shift = MODE_MAX - mode;

   // Odd fractions of the line length: (2i+1)*chars / 2^mode
   always_comb begin
      for (int i = 0; i < HALF_MAX; i++) begin
         prod[i] = PROD_W'(2 * i + 1) * chars_x;
         frac[i] = prod[i] >> mode;
      end
   end

   // Early steps first, then late steps; the highest step index wins
   always_comb begin
      step = '0;
      if (mode_ok) begin
         for (int i = 0; i < HALF_MAX; i++) begin
            if ((MAG_W'(i) < half) && (tick_x == (chars_x - frac[i]))) begin
               step.hit = 1'b1;
               step.mag = MAG_W'((steps - 5'd1 - MAG_W'(i)) << mag_shift);
            end
         end
         for (int i = HALF_MAX - 1; i >= 0; i--) begin
            if ((MAG_W'(i) < half_up) && (tick_x == frac[i])) begin
               step.hit = 1'b1;
               step.mag = MAG_W'(MAG_W'(i) << mag_shift);
            end
         end
      end
   end

endmodule

[hdl/ssq_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_core: scroll sequencing state and per-request logic
// Holds the registers, the request queue and its pointers, the line and tick
// counters, and computes the result of one request in a single pass.
// ----------------------------------------------------------------------------
module ssq_core #(
   parameter int QUEUE_DEPTH = ssq_pkg::DEF_QUEUE_DEPTH,
   parameter int ROW_BITS    = ssq_pkg::DEF_ROW_BITS,
   parameter int MAX_LINES   = ssq_pkg::DEF_MAX_LINES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ssq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssq_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           fire,
   input  ssq_pkg::req_item_type          req,
   output ssq_pkg::rsp_item_type          res
);
   import ssq_pkg::*;

   localparam int ADDR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int ROW_KEEP = (ROW_BITS < ROW_W) ? ROW_BITS : ROW_W;
   localparam int LINE_CAP = (MAX_LINES < 64) ? MAX_LINES : 64;
   localparam int ABS_W    = $clog2(LINE_CAP + 1);
   localparam int ENTRY_W  = 1 + ABS_W + TAG_W + 2 * ROW_KEEP;

   // Configuration registers
   logic               enable_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [CHARS_W-1:0] chars_ff;

   // Sequencing state
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [ADDR_W-1:0]  head_ff,   head_in;
   logic [ABS_W-1:0]   rem_ff,    rem_in;
   logic               loaded_ff, loaded_in;
   logic [CHARS_W-1:0] tick_ff,   tick_in;
   busy_type           block_ff,  block_in;
   logic [ROW_W-1:0]   ltop_ff,   ltop_in;
   logic [ROW_W-1:0]   lbot_ff,   lbot_in;

   // Queue ports
   logic               q_we;
   logic [ADDR_W-1:0]  q_waddr;
   logic [ENTRY_W-1:0] q_wdata;
   logic [ADDR_W-1:0]  q_raddr;
   logic [ENTRY_W-1:0] q_rdata;

   // Decoded request
   int                 line_clamp;
   logic               in_up;
   logic [ABS_W-1:0]   in_abs;
   logic [ROW_KEEP-1:0] in_top;
   logic [ROW_KEEP-1:0] in_bot;

   // Head entry fields
   logic               h_up;
   logic [ABS_W-1:0]   h_abs;
   logic [TAG_W-1:0]   h_tag;
   logic [ROW_KEEP-1:0] h_top;
   logic [ROW_KEEP-1:0] h_bot;

   // Entry of the line being started or stepped
   logic               use_in;
   logic               e_up;
   logic [ABS_W-1:0]   e_rem;
   logic [TAG_W-1:0]   e_tag;
   logic [ROW_W-1:0]   e_top;
   logic [ROW_W-1:0]   e_bot;

   logic [CHARS_W-1:0] chars_eff;
   logic [SUM_W-1:0]   tail_sum;
   logic [ADDR_W-1:0]  tail;
   logic [ADDR_W-1:0]  head_inc;
   logic               smooth_on;
   step_hit_type       step;

   logic               do_start;
   logic               ofs_en;
   logic signed [OFS_W-1:0] ofs_val;
   logic [ROW_W-1:0]   ofs_top;
   logic [ROW_W-1:0]   ofs_bot;
   logic [ABS_W-1:0]   rem_new;

   ssq_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   ssq_step_match u_step (
      .mode  (mode_ff),
      .chars (chars_eff),
      .tick  (tick_ff),
      .step  (step)
   );

   // Saturate and split the requested line count
   always_comb begin
      line_clamp = int'(req.line_count);
      if (line_clamp > MAX_LINES) begin
         line_clamp = MAX_LINES;
      end else if (line_clamp < -MAX_LINES) begin
         line_clamp = -MAX_LINES;
      end
   end

   assign in_up  = line_clamp > 0;
   assign in_abs = ABS_W'((line_clamp < 0) ? -line_clamp : line_clamp);
   assign in_top = req.region_top[ROW_KEEP-1:0];
   assign in_bot = req.region_bottom[ROW_KEEP-1:0];

   // Unpack the head entry
   assign h_up  = q_rdata[ENTRY_W-1];
   assign h_abs = q_rdata[ENTRY_W-2 -: ABS_W];
   assign h_tag = q_rdata[2*ROW_KEEP +: TAG_W];
   assign h_top = q_rdata[ROW_KEEP +: ROW_KEEP];
   assign h_bot = q_rdata[0 +: ROW_KEEP];

   // An enqueue into an empty queue starts from the request itself
   assign use_in = (req.kind == REQ_ENQUEUE);
   assign e_up   = use_in ? in_up : h_up;
   assign e_rem  = use_in ? in_abs : (loaded_ff ? rem_ff : h_abs);
   assign e_tag  = use_in ? req.action_tag : h_tag;
   assign e_top  = ROW_W'(use_in ? in_top : h_top);
   assign e_bot  = ROW_W'(use_in ? in_bot : h_bot);

   assign chars_eff = (chars_ff < CHARS_MIN) ? CHARS_MIN : chars_ff;
   assign smooth_on = enable_ff && (mode_ff != '0);

   // Tail and next head with wrap at the queue depth
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                     ? ADDR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : ADDR_W'(tail_sum);
   assign head_inc = (head_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign q_waddr = tail;
   assign q_wdata = {in_up, in_abs, req.action_tag, in_top, in_bot};
   assign q_raddr = head_in;
   assign rem_new = (e_rem != '0) ? e_rem - 1'b1 : '0;

   // Process one request
   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      rem_in    = rem_ff;
      loaded_in = loaded_ff;
      tick_in   = tick_ff;
      block_in  = block_ff;
      ltop_in   = ltop_ff;
      lbot_in   = lbot_ff;
      q_we      = 1'b0;
      res       = '0;
      do_start  = 1'b0;
      ofs_en    = 1'b0;
      ofs_val   = '0;
      ofs_top   = e_top;
      ofs_bot   = e_bot;

      if (fire) begin
         case (req.kind)
            REQ_TICK: begin
               if (block_ff == BUSY_LINE_DONE) begin
                  block_in = BUSY_IDLE;
               end
               if (count_ff != '0) begin
                  if (tick_ff == '0) begin
                     do_start = 1'b1;
                  end else if (tick_ff == 8'd1) begin
                     // end of line: drop the offset, pop after the last line
                     ofs_en  = 1'b1;
                     tick_in = '0;
                     if (rem_ff == '0) begin
                        head_in  = head_inc;
                        count_in = count_ff - 1'b1;
                        if (count_ff == CNT_W'(1)) begin
                           block_in = BUSY_LINE_DONE;
                        end else begin
                           loaded_in = 1'b0;
                        end
                     end
                  end else begin
                     if (step.hit) begin
                        ofs_en  = 1'b1;
                        ofs_val = e_up ? -$signed(OFS_W'(step.mag))
                                       : $signed(OFS_W'(step.mag));
                     end
                     tick_in = tick_ff - 1'b1;
                  end
               end
            end
            REQ_ENQUEUE: begin
               if (line_clamp != 0) begin
                  if (!smooth_on || (count_ff >= CNT_W'(QUEUE_DEPTH))) begin
                     // scroll and finish at once
                     res.move_lines = LINE_W'(line_clamp);
                     res.finish_now = 1'b1;
                     res.finish_tag = req.action_tag;
                  end else begin
                     q_we     = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (count_ff == '0) begin
                        do_start = 1'b1;
                     end else begin
                        block_in = BUSY_BLOCKED;
                     end
                  end
               end
            end
            REQ_CLEAR: begin
               ofs_en    = 1'b1;
               ofs_top   = ltop_ff;
               ofs_bot   = lbot_ff;
               count_in  = '0;
               head_in   = '0;
               rem_in    = '0;
               loaded_in = 1'b1;
               tick_in   = '0;
               block_in  = BUSY_IDLE;
            end
            default: begin
            end
         endcase

         // Start a line: move one line, full offset, arm the tick counter
         if (do_start) begin
            res.move_lines = e_up ? 7'sd1 : -7'sd1;
            rem_in    = rem_new;
            loaded_in = 1'b1;
            if (rem_new == '0) begin
               res.finish_now = 1'b1;
               res.finish_tag = e_tag;
               block_in       = BUSY_LINE_DONE;
            end
            ofs_en  = 1'b1;
            ofs_val = e_up ? -$signed(OFS_W'(OFFSET_FULL)) : $signed(OFS_W'(OFFSET_FULL));
            tick_in = chars_eff - 1'b1;
         end

         // Write the offset and remember its region while nonzero
         if (ofs_en) begin
            res.offset_write  = 1'b1;
            res.pixel_offset  = ofs_val;
            res.offset_top    = ofs_top;
            res.offset_bottom = ofs_bot;
            if (ofs_val == '0) begin
               ltop_in = LAST_TOP_IDLE;
               lbot_in = LAST_BOT_IDLE;
            end else begin
               ltop_in = ofs_top;
               lbot_in = ofs_bot;
            end
         end

         if ((req.kind == REQ_TICK) && (count_ff == '0)) begin
            res.busy_status = BUSY_IDLE;
         end else begin
            res.busy_status = block_in;
         end
      end
   end

   // Advance the sequencing state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         head_ff   <= '0;
         rem_ff    <= '0;
         loaded_ff <= 1'b1;
         tick_ff   <= '0;
         block_ff  <= BUSY_IDLE;
         ltop_ff   <= LAST_TOP_IDLE;
         lbot_ff   <= LAST_BOT_IDLE;
      end else begin
         count_ff  <= count_in;
         head_ff   <= head_in;
         rem_ff    <= rem_in;
         loaded_ff <= loaded_in;
         tick_ff   <= tick_in;
         block_ff  <= block_in;
         ltop_ff   <= ltop_in;
         lbot_ff   <= lbot_in;
      end
   end

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         mode_ff   <= '0;
         chars_ff  <= CHARS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SMOOTH_ENABLE: enable_ff <= csr_wdata[0];
            CSR_SMOOTH_MODE:   mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_SCROLL_CHARS:  chars_ff  <= csr_wdata[CHARS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Queue never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // No line is in progress while the queue is empty
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (tick_ff == '0))
      else $error("tick counter running on empty queue");

   // Clear empties the queue and rewinds the head
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (fire && (req.kind == REQ_CLEAR)) |=> ((count_ff == '0) && (head_ff == '0)))
      else $error("clear left queue state behind");

   // A finish always comes with a text move
   a_finish_moves: assert property (@(posedge clock) disable iff (reset)
      (fire && res.finish_now) |-> (res.move_lines != '0))
      else $error("finish without line move");

endmodule

[hdl/smooth_scroll_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_scroll_sequencer: terminal smooth scroll timing sequencer
// Queues scroll requests and turns frame ticks into line moves, pixel offset
// steps and deferred action finishes.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while results are accepted and
// returns exactly one result for each: a tick, an enqueue, a clear or an
// unknown kind. A request passes an input register, is worked in one pass
// against the queue head and the tick counter once the output register is
// free, and its result lands in that register; a stalled result keeps the
// request in the input register and stops the next one from entering. The
// queue head comes from a registered memory read port that follows the head
// pointer. Stored requests need no clearing after reset. Configuration writes
// take effect on the next cycle and are meant for when the block is idle.
// ----------------------------------------------------------------------------
module smooth_scroll_sequencer #(
   parameter int QUEUE_DEPTH = ssq_pkg::DEF_QUEUE_DEPTH,
   parameter int ROW_BITS    = ssq_pkg::DEF_ROW_BITS,
   parameter int MAX_LINES   = ssq_pkg::DEF_MAX_LINES
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // line_count[6:0], action_tag[14:7], region_top[22:15], region_bottom[30:23]
   input  logic [ssq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [ssq_pkg::KIND_W-1:0]      req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // move_lines[6:0], offset_write[7], pixel_offset[13:8], offset_top[21:14],
   // offset_bottom[29:22], finish_now[30], finish_tag[38:31], busy_status[40:39]
   output logic [ssq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register writes
   input  logic                            csr_wr_en,
   input  logic [ssq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ssq_pkg::*;

   localparam int RSP_W = $bits(rsp_item_type);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type res;
   logic         fire;
   logic         req_take;

   // Work the held request once the output register is free
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   ssq_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ROW_BITS    (ROW_BITS),
      .MAX_LINES   (MAX_LINES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .req       (in_item_ff),
      .res       (res)
   );

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture request and result payloads
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind          <= req_kind_type'(req_tuser);
         in_item_ff.line_count    <= req_tdata[LINE_W-1:0];
         in_item_ff.action_tag    <= req_tdata[LINE_W +: TAG_W];
         in_item_ff.region_top    <= req_tdata[LINE_W+TAG_W +: ROW_W];
         in_item_ff.region_bottom <= req_tdata[LINE_W+TAG_W+ROW_W +: ROW_W];
      end
      if (fire) begin
         out_item_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_W){1'b0}}, out_item_ff};

endmodule

[verif/smooth_scroll_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_scroll_sequencer_tb: self-checking bench for the smooth scroll sequencer
// Streams tick, enqueue, clear and spare-kind requests into the block under a
// range of register settings and idle patterns. Each accepted request runs
// through a scroll timing predictor, and every result is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module smooth_scroll_sequencer_tb;
   import ssq_pkg::*;

   localparam int DEPTH      = DEF_QUEUE_DEPTH;
   localparam int LINE_LIMIT = DEF_MAX_LINES;
   localparam int PHASES     = 13;
   localparam int PHASE_REQS = 132;
   localparam int RUN_LIMIT  = 400000;

   // request kind the block must ignore
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   // register settings per phase; phase 0 carries the directed requests
   localparam int PH_ENABLE [PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 0, 1};
   localparam int PH_MODE   [PHASES] = '{5, 1, 2, 3, 4, 5, 5, 6, 7, 0, 5, 3, 5};
   localparam int PH_CHARS  [PHASES] = '{16, 2, 255, 7, 33, 16, 16, 10, 1, 0, 0, 200, 3};
   // idle patterns, rotated across phases
   localparam int SEND_IDLE [4] = '{0, 80, 0, 11};
   localparam int RECV_IDLE [4] = '{0, 0, 80, 11};

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic signed [LINE_W-1:0] lines;
      logic [TAG_W-1:0]         tag;
      logic [ROW_W-1:0]         top;
      logic [ROW_W-1:0]         bot;
   } scroll_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]      req_tuser  = REQ_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_SMOOTH_ENABLE;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // stimulus and scoreboard storage
   scroll_req_type requests_to_send[$];
   rsp_item_type   scroll_results_due[$];
   scroll_req_type req_on_bus;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int faults = 0;
   int cycles = 0;

   // predictor copy of the registers
   logic             cfg_enable = 1'b0;
   logic [MODE_W-1:0] cfg_mode  = '0;
   logic [CHARS_W-1:0] cfg_chars = CHARS_RESET;

   // predictor copy of the scroll queue and timing state
   int               entry_lines [DEPTH];
   logic [TAG_W-1:0] entry_tag   [DEPTH];
   logic [ROW_W-1:0] entry_top   [DEPTH];
   logic [ROW_W-1:0] entry_bot   [DEPTH];
   int       queued     = 0;
   int       head_idx   = 0;
   int       lines_left = 0;
   int       ticks_left = 0;
   busy_type status     = BUSY_IDLE;
   logic [ROW_W-1:0] live_top = LAST_TOP_IDLE;
   logic [ROW_W-1:0] live_bot = LAST_BOT_IDLE;

   smooth_scroll_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Scroll timing predictor
   // ---------------------------------------------------------------------
   function automatic int effective_chars();
      return (cfg_chars < CHARS_MIN) ? int'(CHARS_MIN) : int'(cfg_chars);
   endfunction

   // record a new pixel offset; a zero offset retires the live region
   function automatic void apply_offset(inout rsp_item_type r, input logic [ROW_W-1:0] top,
                                        input logic [ROW_W-1:0] bot, input int ofs);
      r.offset_write  = 1'b1;
      r.pixel_offset  = OFS_W'(ofs);
      r.offset_top    = top;
      r.offset_bottom = bot;
      if (ofs == 0) begin
         live_top = LAST_TOP_IDLE;
         live_bot = LAST_BOT_IDLE;
      end else begin
         live_top = top;
         live_bot = bot;
      end
   endfunction

   // move one line of the head entry and set the full offset
   function automatic void begin_line(inout rsp_item_type r);
      bit up;
      up = entry_lines[head_idx] > 0;
      r.move_lines = LINE_W'(up ? 1 : -1);
      if (lines_left > 0)
         lines_left--;
      if (lines_left == 0) begin
         r.finish_now = 1'b1;
         r.finish_tag = entry_tag[head_idx];
         status = BUSY_LINE_DONE;
      end
      apply_offset(r, entry_top[head_idx], entry_bot[head_idx],
                   up ? -int'(OFFSET_FULL) : int'(OFFSET_FULL));
      ticks_left = effective_chars() - 1;
   endfunction

   function automatic rsp_item_type scroll_step(scroll_req_type rq);
      rsp_item_type r;
      int lines, idx, m, n, d, k, pos, mag, c;
      bit hit;
      r = '0;
      case (rq.kind)
         REQ_TICK: begin
            if (status == BUSY_LINE_DONE)
               status = BUSY_IDLE;
            if (queued != 0) begin
               if (ticks_left == 0) begin
                  begin_line(r);
               end else if (ticks_left == 1) begin
                  // end of line: clear the offset, pop after the last line
                  apply_offset(r, entry_top[head_idx], entry_bot[head_idx], 0);
                  ticks_left = 0;
                  if (lines_left == 0) begin
                     head_idx = (head_idx + 1) % DEPTH;
                     queued--;
                     if (queued == 0)
                        status = BUSY_LINE_DONE;
                     else
                        lines_left = (entry_lines[head_idx] < 0) ? -entry_lines[head_idx]
                                                                 : entry_lines[head_idx];
                  end
               end else begin
                  // intermediate offset steps at fixed tick positions
                  m = cfg_mode;
                  c = effective_chars();
                  hit = 1'b0;
                  mag = 0;
                  if (m >= MODE_MIN && m <= MODE_MAX) begin
                     n = 1 << (m - 1);
                     d = 1 << m;
                     for (k = 0; k < n; k++) begin
                        if (k < n / 2)
                           pos = c - ((2 * k + 1) * c) / d;
                        else
                           pos = ((2 * (n - 1 - k) + 1) * c) / d;
                        if (ticks_left == pos) begin
                           hit = 1'b1;
                           mag = (int'(OFFSET_FULL) * (n - 1 - k)) / n;
                        end
                     end
                  end
                  if (hit)
                     apply_offset(r, entry_top[head_idx], entry_bot[head_idx],
                                  entry_lines[head_idx] > 0 ? -mag : mag);
                  ticks_left--;
               end
            end
         end
         REQ_ENQUEUE: begin
            lines = rq.lines;
            if (lines > LINE_LIMIT)
               lines = LINE_LIMIT;
            if (lines < -LINE_LIMIT)
               lines = -LINE_LIMIT;
            if (lines != 0) begin
               if (!(cfg_enable && cfg_mode != 0) || queued >= DEPTH) begin
                  // scroll and finish at once
                  r.move_lines = LINE_W'(lines);
                  r.finish_now = 1'b1;
                  r.finish_tag = rq.tag;
               end else begin
                  idx = (head_idx + queued) % DEPTH;
                  entry_lines[idx] = lines;
                  entry_tag[idx]   = rq.tag;
                  entry_top[idx]   = rq.top;
                  entry_bot[idx]   = rq.bot;
                  queued++;
                  if (queued == 1) begin
                     lines_left = (lines < 0) ? -lines : lines;
                     begin_line(r);
                  end else begin
                     status = BUSY_BLOCKED;
                  end
               end
            end
         end
         REQ_CLEAR: begin
            apply_offset(r, live_top, live_bot, 0);
            queued     = 0;
            head_idx   = 0;
            lines_left = 0;
            ticks_left = 0;
            status     = BUSY_IDLE;
         end
         default: ;
      endcase
      r.busy_status = status;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request generation
   // ---------------------------------------------------------------------
   function automatic scroll_req_type make_request(logic [KIND_W-1:0] kind, int lines,
                                                   int tag, int top, int bot);
      scroll_req_type rq;
      rq.kind  = kind;
      rq.lines = LINE_W'(lines);
      rq.tag   = TAG_W'(tag);
      rq.top   = ROW_W'(top);
      rq.bot   = ROW_W'(bot);
      return rq;
   endfunction

   // mostly ticks and short scrolls, a few long or raw line counts
   function automatic scroll_req_type random_request(bit enqueue_only);
      scroll_req_type rq;
      int sel, shape, mag;
      rq = make_request(REQ_TICK, $urandom, $urandom, $urandom, $urandom);
      sel = enqueue_only ? 80 : $urandom_range(99);
      if (sel < 75) begin
         rq.kind = REQ_TICK;
      end else if (sel < 95) begin
         rq.kind = REQ_ENQUEUE;
         shape = $urandom_range(9);
         mag = (shape < 7) ? $urandom_range(3, 1) : (shape == 7) ? 0 : $urandom_range(24, 4);
         if (shape != 8)
            rq.lines = LINE_W'($urandom_range(1) ? -mag : mag);
      end else if (sel < 98) begin
         rq.kind = REQ_CLEAR;
      end else begin
         rq.kind = KIND_SPARE;
      end
      return rq;
   endfunction

   task automatic push_random(int count);
      int i, burst;
      i = 0;
      while (i < count) begin
         if ($urandom_range(99) < 2) begin
            // enqueue burst to run the queue into its full state
            burst = $urandom_range(18, 4);
            repeat (burst) requests_to_send.push_back(random_request(1'b1));
            i += burst;
         end else begin
            requests_to_send.push_back(random_request(1'b0));
            i++;
         end
      end
   endtask

   task automatic push_directed();
      int i;
      requests_to_send.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
      requests_to_send.push_back(make_request(REQ_ENQUEUE, 0, 8'h5A, 3, 9));
      requests_to_send.push_back(make_request(REQ_ENQUEUE, -64, 0, 255, 0));
      requests_to_send.push_back(make_request(REQ_ENQUEUE, 63, 255, 0, 255));
      // fill the queue, then one more request while full
      for (i = 0; i < DEPTH - 2; i++)
         requests_to_send.push_back(make_request(REQ_ENQUEUE, (i % 2) ? -1 : 1, i + 1, i,
                                                 i + 20));
      requests_to_send.push_back(make_request(REQ_ENQUEUE, 2, 8'hC3, 5, 6));
      requests_to_send.push_back(make_request(KIND_SPARE, -1, 8'hFF, 8'hFF, 8'hFF));
      requests_to_send.push_back(make_request(REQ_CLEAR, 0, 0, 0, 0));
      requests_to_send.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
   endtask

   task automatic wait_drained();
      while (requests_to_send.size() != 0 || req_tvalid || scroll_results_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_SMOOTH_ENABLE: cfg_enable = value[0];
         CSR_SMOOTH_MODE:   cfg_mode   = value[MODE_W-1:0];
         CSR_SCROLL_CHARS:  cfg_chars  = value[CHARS_W-1:0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset, then per phase settle, program registers, stream
   // ---------------------------------------------------------------------
   initial begin
      int p;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         write_reg(CSR_SMOOTH_ENABLE, PH_ENABLE[p]);
         write_reg(CSR_SMOOTH_MODE, PH_MODE[p]);
         write_reg(CSR_SCROLL_CHARS, PH_CHARS[p]);
         @(posedge clock);
         csr_wr_en <= 1'b0;
         @(negedge clock);
         sender_idle_pct = SEND_IDLE[p % 4];
         rsp_stall_pct   = RECV_IDLE[p % 4];
         if (p == 0) begin
            push_directed();
         end else begin
            // hold off halfway until every result is back
            push_random(PHASE_REQS / 2);
            wait_drained();
            push_random(PHASE_REQS - PHASE_REQS / 2);
         end
      end
      wait_drained();
      repeat (8) @(posedge clock);
      if (faults == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: predict on acceptance, then present the next request or idle
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            scroll_results_due.push_back(scroll_step(req_on_bus));
         if (!req_tvalid || req_tready) begin
            if (requests_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_on_bus = requests_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, req_on_bus.bot, req_on_bus.top, req_on_bus.tag,
                              req_on_bus.lines};
               req_tuser  <= req_on_bus.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result with the oldest prediction
   // ---------------------------------------------------------------------
   function automatic int field_differs(string name, longint want, longint got);
      if (want == got)
         return 0;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_item_type got, want;
      int bad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_item_type)-1:0];
            if (scroll_results_due.size() == 0) begin
               $display("%0t: result with none pending, expected nothing, got %h",
                        $time, got);
               faults++;
            end else begin
               want = scroll_results_due.pop_front();
               bad = 0;
               bad += field_differs("move_lines", want.move_lines, got.move_lines);
               bad += field_differs("offset_write", want.offset_write, got.offset_write);
               bad += field_differs("pixel_offset", want.pixel_offset, got.pixel_offset);
               bad += field_differs("offset_top", want.offset_top, got.offset_top);
               bad += field_differs("offset_bottom", want.offset_bottom, got.offset_bottom);
               bad += field_differs("finish_now", want.finish_now, got.finish_now);
               bad += field_differs("finish_tag", want.finish_tag, got.finish_tag);
               bad += field_differs("busy_status", longint'(want.busy_status),
                                    longint'(got.busy_status));
               if (bad != 0)
                  faults++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycles++;
      if (cycles == RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule

[files.f]
hdl/ssq_pkg.sv
hdl/ssq_queue.sv
hdl/ssq_step_match.sv
hdl/ssq_core.sv
hdl/smooth_scroll_sequencer.sv
verif/smooth_scroll_sequencer_tb.sv
